@@ rtl/mhpq_pkg.sv @@
package mhpq_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int ID_W   = 10;
    localparam int KEY_W  = 32;
    localparam int ENTRY_W = ID_W + KEY_W;
    localparam int CNT_W  = 11;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_LOWERED = 2'd3;

endpackage

@@ rtl/mhpq_ram.sv @@
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ rtl/min_heap_priority_queue.sv @@
// Insert and decrease-key sift up a level at a time: read the parent, compare and write
// the parent down, write the sifted entry up. Extract sifts down a level at a time: read
// the left child, read the right child, compare and write the smaller child up, write
// the sifted entry down. Decrease-key first scans the heap one entry per cycle.
// Throughput is one command at a time, set by the single read port of the heap memory.
// Reset (aresetn low, synchronous) empties the heap; memory contents are not cleared.
module min_heap_priority_queue #(
    parameter int MAX_ENTRIES = mhpq_pkg::MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: cmd[1:0], item_id[11:2], item_key[43:12]; zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0: status[1:0], out_id[11:2], out_key[43:12],
    // entry_count[54:44]; zero pad
    output logic [55:0] m_tdata
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int FW = $clog2(MAX_ENTRIES + 1);

    // Entries hold the key with its sign flipped so unsigned compares give signed order.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] bkey;
    } entry_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_UP_RD  = 12'b000000000010,
        S_UP_CMP = 12'b000000000100,
        S_UP_WR  = 12'b000000001000,
        S_DN_RDL = 12'b000000010000,
        S_DN_RDR = 12'b000000100000,
        S_DN_CMP = 12'b000001000000,
        S_DN_WR  = 12'b000010000000,
        S_EX_RD  = 12'b000100000000,
        S_SCAN   = 12'b001000000000,
        S_EX_RT  = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] pos_reg, pos_next, oth_reg, oth_next;
    logic [FW-1:0] scan_reg, scan_next;
    entry_t mov_reg, mov_next;     // the entry being sifted
    entry_t best_reg, best_next;   // smallest of the sifted entry and its children so far
    logic   has_best_reg, has_best_next;
    logic [1:0] st_reg, st_next;
    entry_t res_reg, res_next;
    logic [ID_W-1:0]  qid_reg, qid_next;
    logic [KEY_W-1:0] qkey_reg, qkey_next;
    logic out_v_reg, out_v_next;
    logic [55:0] out_reg, out_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t wr_data, rd_data;

    mhpq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_heap (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Child indexes are computed wide so overflow past the heap is visible.
    logic [AW+1:0] lchild, rchild;
    logic [AW-1:0] parent;
    assign lchild = {1'b0, pos_reg, 1'b1};
    assign rchild = {1'b0, pos_reg, 1'b0} + (AW+2)'(2);
    assign parent = AW'((pos_reg - AW'(1)) >> 1);

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        oth_next = oth_reg;
        scan_next = scan_reg;
        mov_next = mov_reg;
        best_next = best_reg;
        has_best_next = has_best_reg;
        st_next = st_reg;
        res_next = res_reg;
        qid_next = qid_reg;
        qkey_next = qkey_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg;
        wr_data = mov_reg;
        rd_addr = pos_reg;
        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    qid_next  = s_tdata[11:2];
                    qkey_next = s_tdata[43:12] ^ {1'b1, {(KEY_W-1){1'b0}}};
                    st_next   = ST_OK;
                    res_next  = '0;
                    state_next = S_DONE;
                    unique case (s_tdata[1:0])
                        CMD_INSERT: begin
                            if (fill_reg >= FW'(MAX_ENTRIES)) begin
                                st_next = ST_FULL;
                            end else begin
                                pos_next = AW'(fill_reg);
                                mov_next = '{id: s_tdata[11:2],
                                             bkey: s_tdata[43:12] ^ {1'b1, {(KEY_W-1){1'b0}}}};
                                fill_next = fill_reg + FW'(1);
                                wr_en = 1'b1;
                                wr_addr = AW'(fill_reg);
                                wr_data = '{id: s_tdata[11:2],
                                            bkey: s_tdata[43:12] ^ {1'b1, {(KEY_W-1){1'b0}}}};
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (fill_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                fill_next = fill_reg - FW'(1);
                                rd_addr = '0;
                                state_next = S_EX_RT;
                            end
                        end
                        CMD_DECREASE: begin
                            st_next = ST_NOT_LOWERED;
                            scan_next = '0;
                            rd_addr = '0;
                            if (fill_reg != '0) begin
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EX_RT: begin
                // Root data is out; fetch the last entry.
                res_next = rd_data;
                res_next.bkey = rd_data.bkey ^ {1'b1, {(KEY_W-1){1'b0}}};
                rd_addr = AW'(fill_reg);
                state_next = S_EX_RD;
            end
            S_EX_RD: begin
                if (fill_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    mov_next = rd_data;
                    pos_next = '0;
                    wr_en = 1'b1;
                    wr_addr = '0;
                    wr_data = rd_data;
                    state_next = S_DN_RDL;
                end
            end
            S_SCAN: begin
                // rd_data holds entry scan_reg; prefetch the next one.
                rd_addr = AW'(scan_reg + FW'(1));
                if (rd_data.id == qid_reg && rd_data.bkey > qkey_reg) begin
                    st_next = ST_OK;
                    pos_next = AW'(scan_reg);
                    mov_next = '{id: rd_data.id, bkey: qkey_reg};
                    wr_en = 1'b1;
                    wr_addr = AW'(scan_reg);
                    wr_data = '{id: rd_data.id, bkey: qkey_reg};
                    state_next = S_UP_RD;
                end else if (scan_reg + FW'(1) >= fill_reg) begin
                    state_next = S_DONE;
                end else begin
                    scan_next = scan_reg + FW'(1);
                end
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    rd_addr = parent;
                    oth_next = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (rd_data.bkey <= mov_reg.bkey) begin
                    state_next = S_DONE;
                end else begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = rd_data;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                wr_en = 1'b1;
                wr_addr = oth_reg;
                wr_data = mov_reg;
                pos_next = oth_reg;
                state_next = S_UP_RD;
            end
            S_DN_RDL: begin
                has_best_next = 1'b0;
                if (lchild >= (AW+2)'(fill_reg)) begin
                    state_next = S_DONE;
                end else begin
                    rd_addr = AW'(lchild);
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                rd_addr = AW'(rchild);
                if (rd_data.bkey < mov_reg.bkey) begin
                    best_next = rd_data;
                    has_best_next = 1'b1;
                    oth_next = AW'(lchild);
                end else begin
                    best_next = mov_reg;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (rchild < (AW+2)'(fill_reg) && rd_data.bkey < best_reg.bkey) begin
                    best_next = rd_data;
                    has_best_next = 1'b1;
                    oth_next = AW'(rchild);
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = rd_data;
                    state_next = S_DN_WR;
                end else if (has_best_reg) begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = best_reg;
                    state_next = S_DN_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_WR: begin
                wr_en = 1'b1;
                wr_addr = oth_reg;
                wr_data = mov_reg;
                pos_next = oth_reg;
                state_next = S_DN_RDL;
            end
            S_DONE: begin
                out_v_next = 1'b1;
                out_next = {1'b0, CNT_W'(fill_reg), res_reg.bkey, res_reg.id, st_reg};
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            out_v_reg <= out_v_next;
        end
        pos_reg <= pos_next;
        oth_reg <= oth_next;
        scan_reg <= scan_next;
        mov_reg <= mov_next;
        best_reg <= best_next;
        has_best_reg <= has_best_next;
        st_reg <= st_next;
        res_reg <= res_next;
        qid_reg <= qid_next;
        qkey_reg <= qkey_next;
        out_reg <= out_next;
    end
endmodule

@@ tb/min_heap_priority_queue_tb.sv @@
module min_heap_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mhpq_pkg::*;

    localparam int DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One command as the block sees it on the input stream.
    typedef struct packed {
        logic [31:0] item_key;
        logic [9:0]  item_id;
        logic [1:0]  cmd;
    } heap_cmd_t;

    // One response as the block returns it on the result stream.
    typedef struct packed {
        logic [10:0] entry_count;
        logic [31:0] out_key;
        logic [9:0]  out_id;
        logic [1:0]  status;
    } heap_resp_t;

    // The scoreboard keeps its own heap, applies each accepted command to it, and queues
    // the response that the block must return for that command.
    class heap_scoreboard;
        logic [9:0]  ids[DEPTH];
        logic [31:0] keys[DEPTH];
        int          fill;
        heap_resp_t  pending[$];
        int          errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // Keys are compared as signed values throughout.
        function bit key_less(logic [31:0] a, logic [31:0] b);
            return $signed(a) < $signed(b);
        endfunction

        function void swap_entries(int a, int b);
            logic [9:0]  ti;
            logic [31:0] tk;
            ti = ids[a];
            tk = keys[a];
            ids[a] = ids[b];
            keys[a] = keys[b];
            ids[b] = ti;
            keys[b] = tk;
        endfunction

        // Moves an entry up while its parent holds a strictly larger key.
        function void bubble_up(int pos);
            int up;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (!key_less(keys[pos], keys[up])) break;
                swap_entries(up, pos);
                pos = up;
            end
        endfunction

        // Moves an entry down; the left child wins ties, and the walk stops as soon as
        // no child is strictly smaller.
        function void bubble_down(int pos);
            int best;
            int l;
            forever begin
                best = pos;
                l = 2 * pos + 1;
                if (l < fill && key_less(keys[l], keys[best])) best = l;
                if (l + 1 < fill && key_less(keys[l + 1], keys[best])) best = l + 1;
                if (best == pos) break;
                swap_entries(pos, best);
                pos = best;
            end
        endfunction

        function void note_command(heap_cmd_t c);
            heap_resp_t r;
            r = '0;
            r.status = ST_OK;
            case (c.cmd)
                CMD_INSERT: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ids[fill] = c.item_id;
                        keys[fill] = c.item_key;
                        fill++;
                        bubble_up(fill - 1);
                    end
                end
                CMD_EXTRACT: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.out_id = ids[0];
                        r.out_key = keys[0];
                        fill--;
                        ids[0] = ids[fill];
                        keys[0] = keys[fill];
                        if (fill > 0) bubble_down(0);
                    end
                end
                CMD_DECREASE: begin
                    // Only the first entry in storage order that can be lowered changes.
                    r.status = ST_NOT_LOWERED;
                    for (int i = 0; i < fill; i++) begin
                        if (ids[i] == c.item_id && key_less(c.item_key, keys[i])) begin
                            keys[i] = c.item_key;
                            bubble_up(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.entry_count = fill[10:0];
            pending.insert(pending.size(), r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_response(heap_resp_t got);
            heap_resp_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected response", got, 0);
            end else begin
                want = pending.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.out_id != want.out_id)
                    report_mismatch("out_id", got.out_id, want.out_id);
                if (got.out_key != want.out_key)
                    report_mismatch("out_key", $signed(got.out_key), $signed(want.out_key));
                if (got.entry_count != want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // cmd, item_id, item_key, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status, out_id, out_key, entry_count, zero pad

    heap_scoreboard sb;
    longint cycles = 0;
    bit     quiet_phase;     // while set, neither side idles
    bit     hold_receiver;   // while set, the result side stalls

    min_heap_priority_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // A transaction on either channel is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so ordering inside the time step does not
    // matter.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready) sb.note_command(heap_cmd_t'(s_tdata[43:0]));
        if (aresetn && m_tvalid && m_tready) sb.check_response(heap_resp_t'(m_tdata[54:0]));
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // The result side idles about one cycle in ten, except in the quiet phase, and
    // stalls entirely while the hold-off is in force.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_receiver && (quiet_phase || $urandom_range(99) >= 10);
    end

    // Drives one command and waits until the block takes it. Between commands the
    // sender may idle, so gaps land on every phase of the block's work.
    task send_command(logic [1:0] cmd, logic [9:0] id, logic [31:0] key);
        heap_cmd_t c;
        c.cmd = cmd;
        c.item_id = id;
        c.item_key = key;
        while (!quiet_phase && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Withdraws the input and waits until every accepted command has been answered.
    task wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Keys are drawn either from a narrow band, so that ties are frequent, or from
    // the full signed range.
    function logic [31:0] pick_key();
        if ($urandom_range(1)) return 32'($signed($urandom_range(40)) - 20);
        return $urandom;
    endfunction

    task run_random(int count, int insert_weight);
        int roll;
        logic [9:0] id;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            // Ids come mostly from a small pool so that decrease-key finds matches.
            id = $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(15));
            if (roll < insert_weight)
                send_command(CMD_INSERT, id, pick_key());
            else if (roll < insert_weight + 25)
                send_command(CMD_DECREASE, id, pick_key());
            else if (roll < 98)
                send_command(CMD_EXTRACT, id, pick_key());
            else
                send_command(CMD_UNUSED, id, pick_key());
        end
    endtask

    initial begin
        sb = new();
        quiet_phase = 0;
        hold_receiver = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: the empty heap, the extreme keys and ids, ties, the lowering
        // cases, and the unused command.
        send_command(CMD_EXTRACT, 10'd0, 32'd0);
        send_command(CMD_DECREASE, 10'd5, 32'h8000_0000);
        send_command(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 10'h3FF, 32'h7FFF_FFFF);
        send_command(CMD_INSERT, 10'd0, 32'h8000_0000);
        send_command(CMD_INSERT, 10'd7, 32'd5);
        send_command(CMD_INSERT, 10'd8, 32'd5);
        send_command(CMD_INSERT, 10'd9, 32'd5);
        send_command(CMD_INSERT, 10'd7, 32'd9);
        send_command(CMD_DECREASE, 10'd7, 32'd5);          // lowers the id-7 key 9; the equal key 5 stays
        send_command(CMD_DECREASE, 10'd9, 32'hFFFF_FFFF);  // lowered to -1
        send_command(CMD_DECREASE, 10'd123, 32'd0);        // unknown id
        send_command(CMD_DECREASE, 10'h3FF, 32'h8000_0000);
        send_command(CMD_UNUSED, 10'h2AA, 32'h5555_5555);
        repeat (8) send_command(CMD_EXTRACT, 10'h155, 32'hAAAA_AAAA);

        // Fill to capacity with no idling on either side, provoke the full case, then
        // take some entries out again.
        quiet_phase = 1;
        for (int i = 0; i < DEPTH; i++) send_command(CMD_INSERT, 10'(i), pick_key());
        send_command(CMD_INSERT, 10'h3FF, 32'd1);
        send_command(CMD_DECREASE, 10'd1000, 32'h8000_0000);
        quiet_phase = 0;
        wait_for_drain();
        repeat (100) send_command(CMD_EXTRACT, 10'd0, 32'd0);

        // Random traffic; a hold-off on the result side lets the block back up.
        fork
            begin
                hold_receiver = 1;
                repeat (400) @(posedge aclk);
                hold_receiver = 0;
            end
            run_random(60, 45);
        join
        run_random(50, 35);

        wait_for_drain();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
